// ===== hdl/wsfd_pkg.sv =====
package wsfd_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_DISCARD = 2'd2
	} kind_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [3:0]  frame_opcode;
		logic [15:0] delivered_length;
		logic        last;
	} res_t;

	// register index of max_payload (paddr[2])
	localparam logic REG_MAX_PAYLOAD = 1'b0;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd8192;

	// header constants
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES = 4'd4;

endpackage

// ===== hdl/websocket_frame_decoder.sv =====
// websocket frame decoder: parses frames from a received byte stream
// input channel: one raw byte per item (data_byte), chunk_end set on the last
//   byte of a received chunk; every chunk starts a new frame
// output channel: result items (kind, payload_byte, frame_opcode,
//   delivered_length, last); kind 0 is an unmasked payload byte, kind 1 the
//   frame accept with min(length, max_payload), kind 2 a discard for a chunk
//   that ended before its frame was complete; last marks the final result
//   caused by one input item
// one input byte gives zero, one or two results
// latency: each result is registered in the result queue once its byte is accepted
// throughput: one byte per cycle while the queue has room for two more
//   results; the header/payload state updates in the cycle of acceptance and
//   the results land in a small result queue (RES_DEPTH entries)
// in_ready drops when the queue cannot take two more results, so a stalled
//   receiver holds the input off without losing results
// reset: parser waits for the first header byte, queue empty,
//   max_payload = 8192
// max_payload is written through the apb port at byte address 0

module websocket_frame_decoder
	import wsfd_pkg::*;
#(
	parameter int unsigned RES_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        chunk_end,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [3:0]  frame_opcode,
	output logic [15:0] delivered_length,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT16,
		PH_EXT64,
		PH_MASK,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	// parser state
	phase_t      phase_q, phase_d;
	logic [3:0]  hc_q, hc_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_on_q, mask_on_d;
	logic [31:0] key_q, key_d;
	logic [63:0] flen_q, flen_d;
	logic [63:0] seen_q, seen_d;
	logic [15:0] max_q;

	logic        acc_in;
	logic        len_done;
	logic        hdr_done;
	logic        e_byte, e_acc, e_dis;
	logic [7:0]  byte_val;
	logic [7:0]  key_byte;
	logic [15:0] acc_len;
	logic [1:0]  res_n;
	logic [1:0]  push_n;
	res_t        res_a, res_b, res_acc, res_dis, res_out;
	logic        room2;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {16'd0, max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_PAYLOAD_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_PAYLOAD) begin
			max_q <= pwdata[15:0];
		end
	end

	// ---------------- per-byte parse ----------------
	assign acc_in = in_valid && in_ready;

	// key byte picked by payload index mod 4, msb first
	always_comb begin
		case (seen_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		hc_d      = hc_q;
		opcode_d  = opcode_q;
		mask_on_d = mask_on_q;
		key_d     = key_q;
		flen_d    = flen_q;
		seen_d    = seen_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		e_byte    = 1'b0;
		e_acc     = 1'b0;
		e_dis     = 1'b0;
		byte_val  = data_byte ^ (mask_on_q ? key_byte : 8'd0);
		acc_len   = 16'd0;

		case (phase_q)
			PH_HDR0: begin
				opcode_d = data_byte[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				mask_on_d = data_byte[7];
				hc_d      = 4'd0;
				flen_d    = 64'd0;
				if (data_byte[6:0] == LEN7_EXT16) begin
					phase_d = PH_EXT16;
				end else if (data_byte[6:0] == LEN7_EXT64) begin
					phase_d = PH_EXT64;
				end else begin
					flen_d   = {57'd0, data_byte[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				flen_d = {flen_q[55:0], data_byte};
				hc_d   = hc_q + 4'd1;
				if (hc_d == ((phase_q == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
					len_done = 1'b1;
				end
			end
			PH_MASK: begin
				key_d = {key_q[23:0], data_byte};
				hc_d  = hc_q + 4'd1;
				if (hc_d == KEY_BYTES) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				// bytes past the capacity are consumed but not delivered
				if (seen_q < {48'd0, max_q}) begin
					e_byte = 1'b1;
				end
				seen_d = seen_q + 64'd1;
				if (seen_d == flen_q) begin
					e_acc   = 1'b1;
					acc_len = (flen_q < {48'd0, max_q}) ? flen_q[15:0] : max_q;
					phase_d = PH_SKIP;
				end
			end
			default: begin
				phase_d = PH_SKIP;
			end
		endcase

		// length known: fetch the mask key or finish the header
		if (len_done) begin
			if (mask_on_d) begin
				phase_d = PH_MASK;
				hc_d    = 4'd0;
				key_d   = 32'd0;
			end else begin
				hdr_done = 1'b1;
			end
		end

		// header complete: an empty frame is accepted at once
		if (hdr_done) begin
			seen_d = 64'd0;
			if (flen_d == 64'd0) begin
				phase_d = PH_SKIP;
				e_acc   = 1'b1;
				acc_len = 16'd0;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		// chunk over: discard an unfinished frame and resync
		if (chunk_end) begin
			if (phase_d != PH_SKIP) begin
				e_dis = 1'b1;
			end
			phase_d = PH_HDR0;
		end
	end

	// ---------------- result assembly ----------------
	// byte result comes first; accept and discard never occur together
	always_comb begin
		res_acc = '{kind: KIND_ACCEPT, payload_byte: 8'd0, frame_opcode: opcode_d,
			delivered_length: acc_len, last: 1'b1};
		res_dis = '{kind: KIND_DISCARD, payload_byte: 8'd0, frame_opcode: opcode_d,
			delivered_length: 16'd0, last: 1'b1};
		res_n   = 2'(e_byte) + 2'(e_acc) + 2'(e_dis);
		res_b   = e_acc ? res_acc : res_dis;
		if (e_byte) begin
			res_a = '{kind: KIND_BYTE, payload_byte: byte_val, frame_opcode: opcode_d,
				delivered_length: 16'd0, last: (res_n == 2'd1)};
		end else begin
			res_a = res_b;
		end
	end

	assign push_n = acc_in ? res_n : 2'd0;

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			hc_q      <= 4'd0;
			opcode_q  <= 4'd0;
			mask_on_q <= 1'b0;
			key_q     <= 32'd0;
			flen_q    <= 64'd0;
			seen_q    <= 64'd0;
		end else if (acc_in) begin
			phase_q   <= phase_d;
			hc_q      <= hc_d;
			opcode_q  <= opcode_d;
			mask_on_q <= mask_on_d;
			key_q     <= key_d;
			flen_q    <= flen_d;
			seen_q    <= seen_d;
		end
	end

	// ---------------- result queue ----------------
	wsfd_res_fifo #(
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (res_a),
		.push_b    (res_b),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res_out)
	);

	assign in_ready         = room2;
	assign kind             = res_out.kind;
	assign payload_byte     = res_out.payload_byte;
	assign frame_opcode     = res_out.frame_opcode;
	assign delivered_length = res_out.delivered_length;
	assign last             = res_out.last;

`ifndef ASSERT_OFF
	// a chunk end always returns the parser to the first header byte
	a_chunk_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && chunk_end) |=> (phase_q == PH_HDR0))
		else $error("parser not resynced after chunk end");

	// parser state moves only on an accepted byte
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) |=> $stable(phase_q))
		else $error("phase changed without an input item");

	// while in payload the frame is never already complete
	a_payload_open: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (seen_q < flen_q))
		else $error("payload phase past frame length");

	// mask key collection never overruns four bytes
	a_key_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MASK) |-> (hc_q < KEY_BYTES))
		else $error("mask key byte count overrun");
`endif

endmodule

// ===== hdl/wsfd_res_fifo.sv =====
module wsfd_res_fifo
	import wsfd_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       push_a,
	input  res_t       push_b,
	output logic       room2,
	output logic       out_valid,
	input  logic       out_ready,
	output res_t       out_res
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign room2     = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[ptr_inc(wr_q)] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_q <= ptr_inc(wr_q);
			end else if (push_n == 2'd2) begin
				wr_q <= ptr_inc(ptr_inc(wr_q));
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule
